// ===== hdl/u8dv_pkg.sv =====
// ----------------------------------------------------------------------------
// u8dv_pkg
// Shared types and constants of the UTF-8 stream decoder and validator.
// ----------------------------------------------------------------------------
package u8dv_pkg;

	localparam int CP_W    = 21;
	localparam int OFS_W   = 16;
	localparam int CNT_W   = 17;
	localparam int LEN_W   = 3;
	localparam int PEND_W  = 2;
	localparam int PAY_W   = 7;
	localparam int CNT_MAX = 131071;

	// depth of the queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	// byte class, decided by the top bits
	typedef enum logic [2:0] {
		CLS_ASCII   = 3'd0,
		CLS_CONT    = 3'd1,
		CLS_START2  = 3'd2,
		CLS_START3  = 3'd3,
		CLS_START4  = 3'd4,
		CLS_INVALID = 3'd5
	} byte_cls_t;

	// error codes as reported on error_kind
	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_INVALID   = 3'd1,
		ERR_STRAY     = 3'd2,
		ERR_MID_START = 3'd3,
		ERR_TRUNC     = 3'd4
	} err_t;

	// classified request handed from front to back
	typedef struct packed {
		byte_cls_t        cls;
		logic [PAY_W-1:0] payload;
		logic             last;
	} item_t;

	// one result request
	typedef struct packed {
		logic             cp_ready;
		logic [CP_W-1:0]  code_point;
		logic [LEN_W-1:0] cp_length;
		logic [OFS_W-1:0] cp_start_offset;
		logic [CNT_W-1:0] cp_total;
		err_t             error_kind;
		logic             string_end;
		logic             string_valid;
	} result_t;

endpackage

// ===== hdl/u8dv_front.sv =====
// ----------------------------------------------------------------------------
// u8dv_front
// Accepts raw bytes, classes them and holds one classified request in a
// register until the queue takes it.
// ----------------------------------------------------------------------------
module u8dv_front
	import u8dv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       q_push,
	output item_t      q_item,
	input  logic       q_full
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_c;
	logic  advance;

	// class the byte and strip its marker bits
	always_comb begin
		item_c.last    = last_byte;
		item_c.payload = '0;
		case (data_byte) inside
			[8'h00:8'h7F]: begin
				item_c.cls     = CLS_ASCII;
				item_c.payload = data_byte[6:0];
			end
			[8'h80:8'hBF]: begin
				item_c.cls     = CLS_CONT;
				item_c.payload = {1'b0, data_byte[5:0]};
			end
			[8'hC0:8'hDF]: begin
				item_c.cls     = CLS_START2;
				item_c.payload = {2'b0, data_byte[4:0]};
			end
			[8'hE0:8'hEF]: begin
				item_c.cls     = CLS_START3;
				item_c.payload = {3'b0, data_byte[3:0]};
			end
			[8'hF0:8'hF7]: begin
				item_c.cls     = CLS_START4;
				item_c.payload = {4'b0, data_byte[2:0]};
			end
			default: begin
				item_c.cls = CLS_INVALID;
			end
		endcase
	end

	// stage register moves on when empty or when the queue takes it
	assign q_push  = valid_s1 && !q_full;
	assign advance = !valid_s1 || !q_full;
	assign full    = !advance;
	assign q_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			item_s1 <= item_c;
		end
	end

endmodule

// ===== hdl/u8dv_queue.sv =====
// ----------------------------------------------------------------------------
// u8dv_queue
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module u8dv_queue
	import u8dv_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  item_t wr_item,
	output logic  q_full,
	input  logic  rd_en,
	output item_t rd_item,
	output logic  q_empty
);

	item_t          slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign q_full  = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_item = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ===== hdl/u8dv_back.sv =====
// ----------------------------------------------------------------------------
// u8dv_back
// Sequence state of the decoder: gathers payload bits, tracks offsets,
// counts code points, keeps the first error and registers the result.
// ----------------------------------------------------------------------------
module u8dv_back
	import u8dv_pkg::*;
#(
	parameter int MAX_STRING_BYTES = 65536
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  item_t   q_item,
	output logic    q_pop,
	output logic    out_valid,
	output result_t out_res,
	input  logic    pop
);

	localparam logic [CNT_W-1:0] SAT_LIMIT = (MAX_STRING_BYTES < CNT_MAX) ?
		CNT_W'(MAX_STRING_BYTES) : CNT_W'(CNT_MAX);

	logic [PEND_W-1:0] pend_q;
	logic [LEN_W-1:0]  slen_q;
	logic [CP_W-1:0]   acc_q;
	logic [OFS_W-1:0]  spos_q;
	logic [CNT_W-1:0]  bpos_q;
	logic [CNT_W-1:0]  cnt_q;
	err_t              ferr_q;
	logic              out_valid_q;
	result_t           res_q;

	logic [PEND_W-1:0] pend_n;
	logic [LEN_W-1:0]  slen_n;
	logic [CP_W-1:0]   acc_n;
	logic [OFS_W-1:0]  spos_n;
	logic [CNT_W-1:0]  bpos_n;
	logic [CNT_W-1:0]  cnt_n;
	err_t              ferr_n;
	err_t              ferr_mid;
	err_t              err_c;
	logic [CP_W-1:0]   acc_sh;
	result_t           res_c;

	// take a request when the output register is free or being emptied
	assign q_pop     = !q_empty && (!out_valid_q || pop);
	assign out_valid = out_valid_q;
	assign out_res   = res_q;
	assign acc_sh    = {acc_q[CP_W-7:0], q_item.payload[5:0]};

	// next state and result for the request at the queue head
	always_comb begin
		pend_n = pend_q;
		slen_n = slen_q;
		acc_n  = acc_q;
		spos_n = spos_q;
		err_c  = ERR_NONE;
		res_c  = '0;
		case (q_item.cls)
			CLS_ASCII: begin
				if (pend_q != '0) begin
					err_c = ERR_MID_START;
				end
				pend_n                = '0;
				slen_n                = '0;
				acc_n                 = '0;
				res_c.cp_ready        = 1'b1;
				res_c.code_point      = CP_W'(q_item.payload);
				res_c.cp_length       = LEN_W'(1);
				res_c.cp_start_offset = bpos_q[OFS_W-1:0];
			end
			CLS_CONT: begin
				if (pend_q == '0) begin
					err_c = ERR_STRAY;
				end else begin
					pend_n = pend_q - 1'b1;
					acc_n  = acc_sh;
					if (pend_q == PEND_W'(1)) begin
						res_c.cp_ready        = 1'b1;
						res_c.code_point      = acc_sh;
						res_c.cp_length       = slen_q;
						res_c.cp_start_offset = spos_q;
						slen_n                = '0;
						acc_n                 = '0;
					end
				end
			end
			CLS_START2, CLS_START3, CLS_START4: begin
				if (pend_q != '0) begin
					err_c = ERR_MID_START;
				end
				if (q_item.cls == CLS_START2) begin
					pend_n = PEND_W'(1);
					slen_n = LEN_W'(2);
				end else if (q_item.cls == CLS_START3) begin
					pend_n = PEND_W'(2);
					slen_n = LEN_W'(3);
				end else begin
					pend_n = PEND_W'(3);
					slen_n = LEN_W'(4);
				end
				acc_n  = CP_W'(q_item.payload);
				spos_n = bpos_q[OFS_W-1:0];
			end
			default: begin
				err_c  = ERR_INVALID;
				pend_n = '0;
				slen_n = '0;
				acc_n  = '0;
			end
		endcase

		// sticky first error, then truncation at the end of the string
		ferr_mid = (ferr_q == ERR_NONE) ? err_c : ferr_q;
		if (q_item.last && pend_n != '0 && ferr_mid == ERR_NONE) begin
			ferr_n = ERR_TRUNC;
		end else begin
			ferr_n = ferr_mid;
		end

		// saturating counters
		cnt_n  = (res_c.cp_ready && cnt_q < SAT_LIMIT) ? cnt_q + 1'b1 : cnt_q;
		bpos_n = (bpos_q < SAT_LIMIT) ? bpos_q + 1'b1 : bpos_q;

		res_c.cp_total     = cnt_n;
		res_c.error_kind   = ferr_n;
		res_c.string_end   = q_item.last;
		res_c.string_valid = q_item.last && (ferr_n == ERR_NONE);
	end

	// sequence state, cleared at the end of each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			slen_q <= '0;
			acc_q  <= '0;
			spos_q <= '0;
			bpos_q <= '0;
			cnt_q  <= '0;
			ferr_q <= ERR_NONE;
		end else if (q_pop) begin
			if (q_item.last) begin
				pend_q <= '0;
				slen_q <= '0;
				acc_q  <= '0;
				spos_q <= '0;
				bpos_q <= '0;
				cnt_q  <= '0;
				ferr_q <= ERR_NONE;
			end else begin
				pend_q <= pend_n;
				slen_q <= slen_n;
				acc_q  <= acc_n;
				spos_q <= spos_n;
				bpos_q <= bpos_n;
				cnt_q  <= cnt_n;
				ferr_q <= ferr_n;
			end
		end
	end

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= res_c;
		end
	end

endmodule

// ===== hdl/utf8_stream_decoder_validator.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_validator
// Decodes and checks a UTF-8 byte string, one byte per request.
// ----------------------------------------------------------------------------
// Input channel: drive data_byte and last_byte, raise push; the byte is taken
// on a clock edge with push high and full low. last_byte marks the final
// byte of a string.
// Result channel: one result per byte. While empty is low the oldest result
// sits on the result ports; it is taken on an edge with pop high.
// A result carries the completed code point (cp_ready, code_point, cp_length,
// cp_start_offset), the running code point count, the first error of the
// string so far, and on the last byte string_end and string_valid.
// Path: a taken byte passes the class register, the queue and the result
// register in that order before its result shows on the result ports.
// Throughput: one byte per cycle while full stays low; the sequence update
// in the back part is combinational, so it does not hold the rate below that.
// Stall: if pop stays low the result register holds, the queue fills, and
// full rises once the queue and the class register are occupied.
// Reset: arst_n clears all sequence state, counters, the queue and the
// result valid flag; decoding starts at a fresh string. State also returns to
// zero after each string's last byte.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_validator
	import u8dv_pkg::*;
#(
	parameter int MAX_STRING_BYTES = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              empty,
	input  logic              pop,
	output logic              cp_ready,
	output logic [CP_W-1:0]   code_point,
	output logic [LEN_W-1:0]  cp_length,
	output logic [OFS_W-1:0]  cp_start_offset,
	output logic [CNT_W-1:0]  cp_total,
	output logic [2:0]        error_kind,
	output logic              string_end,
	output logic              string_valid
);

	logic    q_push;
	logic    q_full;
	logic    q_pop;
	logic    q_empty;
	item_t   q_wr_item;
	item_t   q_rd_item;
	logic    out_valid;
	result_t out_res;

	// classify incoming bytes
	u8dv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_push    (q_push),
		.q_item    (q_wr_item),
		.q_full    (q_full)
	);

	// decouple front and back
	u8dv_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (q_wr_item),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_item (q_rd_item),
		.q_empty (q_empty)
	);

	// decode sequences and form results
	u8dv_back #(
		.MAX_STRING_BYTES (MAX_STRING_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (q_rd_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_res   (out_res),
		.pop       (pop)
	);

	// result ports
	assign empty           = !out_valid;
	assign cp_ready        = out_res.cp_ready;
	assign code_point      = out_res.code_point;
	assign cp_length       = out_res.cp_length;
	assign cp_start_offset = out_res.cp_start_offset;
	assign cp_total        = out_res.cp_total;
	assign error_kind      = out_res.error_kind;
	assign string_end      = out_res.string_end;
	assign string_valid    = out_res.string_valid;

	// a valid string ends with no error recorded
	a_valid_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && string_valid) |-> (string_end && error_kind == ERR_NONE))
		else $error("string_valid with an error or off the last byte");

	// a code point is reported exactly when a length is given
	a_ready_len: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (cp_ready == (cp_length != '0)))
		else $error("cp_ready and cp_length disagree");

	// the back part never reads from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	// the front only reports full while the queue is full
	a_full_queue: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_full)
		else $error("full raised with room in the queue");

endmodule
